// ===== rtl/qes_pkg.sv =====
package qes_pkg;

  localparam int COEF_WIDTH     = 32;
  localparam int FRAC_BITS      = 16;
  localparam int COEF_TOL_WIDTH = 16;
  localparam int DISC_TOL_WIDTH = 32;
  localparam int CFG_WIDTH      = 32;
  localparam int CFG_IDX_WIDTH  = 1;

  // register indexes on the write port
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_COEF_TOL = 1'b0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DISC_TOL = 1'b1;

  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_ONE  = 2'd1,
    CNT_TWO  = 2'd2,
    CNT_INF  = 2'd3
  } qes_count_t;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] coef_a;
    logic signed [COEF_WIDTH-1:0] coef_b;
    logic signed [COEF_WIDTH-1:0] coef_c;
  } qes_in_t;

  typedef struct packed {
    logic [1:0]                   root_count;
    logic signed [COEF_WIDTH-1:0] root_first;
    logic signed [COEF_WIDTH-1:0] root_second;
    logic                         saturated;
  } qes_out_t;

endpackage

// ===== rtl/quadratic_equation_solver_unit.sv =====
// Quadratic solver: real roots of a*x^2 + b*x + c = 0, coefficients and roots in
// signed Q16.16.
//
// Request channel: drive in_coef and pulse start. busy is held low, so a request
// is taken on every cycle that start is high: one equation per clock, sustained.
// Result channel: out_strobe is high for one cycle with out_res valid (count,
// up to two roots, saturation flag). The receiver cannot hold results off and
// the block never needs it to: results leave in request order.
// Pipeline: the bit-per-stage square root (COEF_WIDTH+1 stages) followed by
// the bit-per-stage restoring dividers (COEF_WIDTH stages), plus seven stages
// for magnitudes, products, discriminant, case decision, numerators, divider
// set-up and output packing.
// Config: cfg_we/cfg_index/cfg_wdata write coef_tolerance (index 0) and
// disc_tolerance (index 1); write them only when no request is in flight.
// Reset (rst_n low, synchronous): both tolerances clear to zero and every
// pipeline valid bit clears, so requests in flight are dropped.
module quadratic_equation_solver_unit
  import qes_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  qes_in_t                  in_coef,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]     cfg_wdata,
  output logic                     out_strobe,
  output qes_out_t                 out_res
);

  localparam int W  = COEF_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int DW = 2 * W + 2;         // discriminant magnitude, even for bit pairs
  localparam int SW = W + 1;             // square root width
  localparam int RW = SW + 3;            // square root partial remainder
  localparam int EW = W + 3;             // signed -b +/- sqrt(D)
  localparam int NM = W + 2;             // numerator magnitude
  localparam int NW = NM + F + 1;        // scaled and rounded numerator
  localparam int QW = W;                 // quotient bits kept
  localparam int CW = (NW > 2 * W + 1) ? NW : 2 * W + 1;

  typedef struct packed {
    logic [W-1:0] ma;
    logic [W-1:0] mb;
    logic [W-1:0] mc;
    logic         na;
    logic         nb;
    logic         nc;
    logic         za;
    logic         zb;
    logic         zc;
  } coef_t;

  typedef struct packed {
    logic [NM-1:0] m;
    logic [W-1:0]  half;
    logic [W:0]    den;
    logic          neg;
  } div_req_t;

  typedef struct packed {
    qes_count_t   cnt;
    logic [W-1:0] ma;
    logic [W-1:0] mb;
    logic         na;
    logic         nb;
    div_req_t     single;
  } side_t;

  typedef struct packed {
    logic [CW-1:0] rem;
    logic [QW-1:0] q;
    logic [W:0]    den;
    logic          neg;
    logic          ovf;
  } div_lane_t;

  // every request is taken; the pipeline advances unconditionally
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [COEF_TOL_WIDTH-1:0] coef_tol_r;
  logic [DISC_TOL_WIDTH-1:0] disc_tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_tol_r <= '0;
      disc_tol_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COEF_TOL: coef_tol_r <= cfg_wdata[COEF_TOL_WIDTH-1:0];
        CFG_DISC_TOL: disc_tol_r <= cfg_wdata[DISC_TOL_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stage A: sign/magnitude split and near-zero tests
  // ---------------------------------------------------------------------------
  coef_t a_nxt, a_r;
  logic  a_v_r;

  always_comb begin
    a_nxt    = '0;
    a_nxt.na = in_coef.coef_a[W-1];
    a_nxt.nb = in_coef.coef_b[W-1];
    a_nxt.nc = in_coef.coef_c[W-1];
    a_nxt.ma = a_nxt.na ? W'(~in_coef.coef_a + 1'b1) : W'(in_coef.coef_a);
    a_nxt.mb = a_nxt.nb ? W'(~in_coef.coef_b + 1'b1) : W'(in_coef.coef_b);
    a_nxt.mc = a_nxt.nc ? W'(~in_coef.coef_c + 1'b1) : W'(in_coef.coef_c);
    a_nxt.za = a_nxt.ma <= W'(coef_tol_r);
    a_nxt.zb = a_nxt.mb <= W'(coef_tol_r);
    a_nxt.zc = a_nxt.mc <= W'(coef_tol_r);
  end

  // ---------------------------------------------------------------------------
  // stage B: b^2 and a*c
  // ---------------------------------------------------------------------------
  coef_t          b_r;
  logic           b_v_r;
  logic [2*W-1:0] b_pp_r;
  logic [2*W-1:0] b_pq_r;

  // ---------------------------------------------------------------------------
  // stage C: discriminant magnitude and sign
  // ---------------------------------------------------------------------------
  coef_t         c_r;
  logic          c_v_r;
  logic [DW-1:0] c_dm_r;
  logic          c_dneg_r;
  logic [DW-1:0] pp_x, q4_x, dm_nxt;
  logic          dneg_nxt;

  always_comb begin
    pp_x     = DW'(b_pp_r);
    q4_x     = {b_pq_r, 2'b00};
    dneg_nxt = 1'b0;
    dm_nxt   = pp_x + q4_x;
    if ((b_r.mc != '0) && (b_r.na == b_r.nc)) begin
      dneg_nxt = pp_x < q4_x;
      dm_nxt   = dneg_nxt ? (q4_x - pp_x) : (pp_x - q4_x);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      a_v_r <= start && !busy;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    b_r      <= a_r;
    b_pp_r   <= (2 * W)'(a_r.mb) * (2 * W)'(a_r.mb);
    b_pq_r   <= (2 * W)'(a_r.ma) * (2 * W)'(a_r.mc);
    c_r      <= b_r;
    c_dm_r   <= dm_nxt;
    c_dneg_r <= dneg_nxt;
  end

  // ---------------------------------------------------------------------------
  // stage D: pick the case; loads the first square root stage
  // ---------------------------------------------------------------------------
  logic [RW-1:0] sq_rem_r  [0:SW];
  logic [SW-1:0] sq_root_r [0:SW];
  logic [DW-1:0] sq_d_r    [0:SW];
  side_t         sq_side_r [0:SW];
  logic [SW:0]   sq_v_r;
  side_t         d_nxt;
  logic          disc_zero;

  always_comb begin
    disc_zero       = c_dm_r <= DW'(disc_tol_r);
    d_nxt           = '0;
    d_nxt.ma        = c_r.ma;
    d_nxt.mb        = c_r.mb;
    d_nxt.na        = c_r.na;
    d_nxt.nb        = c_r.nb;
    d_nxt.single.den = (W + 1)'(1);
    if (c_r.za) begin
      if (c_r.zb) begin
        d_nxt.cnt = c_r.zc ? CNT_INF : CNT_NONE;
      end else begin
        // linear: x = -c/b
        d_nxt.cnt         = CNT_ONE;
        d_nxt.single.m    = NM'(c_r.mc);
        d_nxt.single.half = c_r.mb >> 1;
        d_nxt.single.den  = (W + 1)'(c_r.mb);
        d_nxt.single.neg  = c_r.nb == c_r.nc;
      end
    end else if (disc_zero) begin
      // double root: x = -b/(2a)
      d_nxt.cnt         = CNT_ONE;
      d_nxt.single.m    = NM'(c_r.mb);
      d_nxt.single.half = c_r.ma;
      d_nxt.single.den  = {c_r.ma, 1'b0};
      d_nxt.single.neg  = c_r.na == c_r.nb;
    end else if (c_dneg_r) begin
      d_nxt.cnt = CNT_NONE;
    end else begin
      d_nxt.cnt = CNT_TWO;
    end
  end

  always_ff @(posedge clk) begin
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
    sq_d_r[0]    <= c_dm_r;
    sq_side_r[0] <= d_nxt;
  end

  // ---------------------------------------------------------------------------
  // square root: one result bit per stage, restoring
  // ---------------------------------------------------------------------------
  generate
    for (genvar k = 0; k < SW; k++) begin : g_sqrt
      logic [RW-1:0] rem2, trial;
      logic          take;

      always_comb begin
        rem2  = {sq_rem_r[k][RW-3:0], sq_d_r[k][DW-1 -: 2]};
        trial = {1'b0, sq_root_r[k], 2'b01};
        take  = rem2 >= trial;
      end

      always_ff @(posedge clk) begin
        sq_rem_r[k+1]  <= take ? (rem2 - trial) : rem2;
        sq_root_r[k+1] <= {sq_root_r[k][SW-2:0], take};
        sq_d_r[k+1]    <= {sq_d_r[k][DW-3:0], 2'b00};
        sq_side_r[k+1] <= sq_side_r[k];
      end
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // stage E: numerators -b -/+ sqrt(D), divider requests
  // ---------------------------------------------------------------------------
  side_t                sd;
  logic signed [EW-1:0] negb, sx, n1, n2, an1, an2;
  div_req_t             e_req_nxt [0:1];
  div_req_t             e_req_r   [0:1];
  qes_count_t           e_cnt_r;
  logic                 e_v_r;

  always_comb begin
    sd  = sq_side_r[SW];
    negb = EW'(sd.mb);
    if (!sd.nb) begin
      negb = -negb;
    end
    sx  = EW'(sq_root_r[SW]);
    n1  = negb - sx;
    n2  = negb + sx;
    an1 = n1[EW-1] ? -n1 : n1;
    an2 = n2[EW-1] ? -n2 : n2;
    if (sd.cnt == CNT_TWO) begin
      e_req_nxt[0] = '{m: NM'(an1), half: sd.ma, den: {sd.ma, 1'b0},
                       neg: n1[EW-1] != sd.na};
    end else begin
      e_req_nxt[0] = sd.single;
    end
    e_req_nxt[1] = '{m: NM'(an2), half: sd.ma, den: {sd.ma, 1'b0},
                     neg: n2[EW-1] != sd.na};
  end

  always_ff @(posedge clk) begin
    e_req_r[0] <= e_req_nxt[0];
    e_req_r[1] <= e_req_nxt[1];
    e_cnt_r    <= sd.cnt;
  end

  // ---------------------------------------------------------------------------
  // dividers: two lanes, set-up stage then one quotient bit per stage
  // ---------------------------------------------------------------------------
  div_lane_t   dv_r     [0:QW][0:1];
  qes_count_t  dv_cnt_r [0:QW];
  logic [QW:0] dv_v_r;

  always_ff @(posedge clk) begin
    dv_cnt_r[0] <= e_cnt_r;
  end

  generate
    for (genvar l = 0; l < 2; l++) begin : g_dset
      logic [CW-1:0] num;

      always_comb begin
        num = (CW'(e_req_r[l].m) << F) + CW'(e_req_r[l].half);
      end

      always_ff @(posedge clk) begin
        dv_r[0][l].rem <= num;
        dv_r[0][l].q   <= '0;
        dv_r[0][l].den <= e_req_r[l].den;
        dv_r[0][l].neg <= e_req_r[l].neg;
        dv_r[0][l].ovf <= num >= (CW'(e_req_r[l].den) << QW);
      end
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
      always_ff @(posedge clk) begin
        dv_cnt_r[k+1] <= dv_cnt_r[k];
      end

      for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [CW-1:0] sh;
        logic          take;

        always_comb begin
          sh   = CW'(dv_r[k][l].den) << (QW - 1 - k);
          take = dv_r[k][l].rem >= sh;
        end

        always_ff @(posedge clk) begin
          dv_r[k+1][l].rem <= take ? (dv_r[k][l].rem - sh) : dv_r[k][l].rem;
          dv_r[k+1][l].q   <= {dv_r[k][l].q[QW-2:0], take};
          dv_r[k+1][l].den <= dv_r[k][l].den;
          dv_r[k+1][l].neg <= dv_r[k][l].neg;
          dv_r[k+1][l].ovf <= dv_r[k][l].ovf;
        end
      end
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // sign, saturation and output register
  // ---------------------------------------------------------------------------
  logic [W-1:0] root_l [0:1];
  logic         sat_l  [0:1];

  generate
    for (genvar l = 0; l < 2; l++) begin : g_pack
      div_lane_t qd;
      logic      negf;

      always_comb begin
        qd        = dv_r[QW][l];
        negf      = qd.neg && (qd.ovf || (qd.q != '0));
        sat_l[l]  = 1'b0;
        root_l[l] = qd.q;
        if (!negf) begin
          if (qd.ovf || qd.q[W-1]) begin
            root_l[l] = {1'b0, {(W - 1){1'b1}}};
            sat_l[l]  = 1'b1;
          end
        end else if (qd.ovf || (qd.q[W-1] && (|qd.q[W-2:0]))) begin
          root_l[l] = {1'b1, {(W - 1){1'b0}}};
          sat_l[l]  = 1'b1;
        end else begin
          root_l[l] = ~qd.q + 1'b1;
        end
      end
    end
  endgenerate

  qes_out_t out_nxt, out_res_r;
  logic     out_strobe_r;

  always_comb begin
    out_nxt            = '0;
    out_nxt.root_count = dv_cnt_r[QW];
    case (dv_cnt_r[QW])
      CNT_ONE: begin
        out_nxt.root_first = root_l[0];
        out_nxt.saturated  = sat_l[0];
      end
      CNT_TWO: begin
        out_nxt.root_first  = root_l[0];
        out_nxt.root_second = root_l[1];
        out_nxt.saturated   = sat_l[0] | sat_l[1];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r       <= '0;
      e_v_r        <= 1'b0;
      dv_v_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      sq_v_r       <= {sq_v_r[SW-1:0], c_v_r};
      e_v_r        <= sq_v_r[SW];
      dv_v_r       <= {dv_v_r[QW-1:0], e_v_r};
      out_strobe_r <= dv_v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

`ifndef NO_ASSERTIONS
  // square root remainder stays within 2*root, i.e. root is the floor
  a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
    sq_v_r[SW] |-> sq_rem_r[SW] <= RW'({sq_root_r[SW], 1'b0}))
    else $error("square root remainder out of range");

  // divider lane 0, if it did not overflow, ends with a remainder below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    dv_v_r[QW] && !dv_r[QW][0].ovf |-> dv_r[QW][0].rem < CW'(dv_r[QW][0].den))
    else $error("divider remainder not below divisor");

  // no root and infinite roots carry zero root fields and no saturation
  a_no_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && ((out_res.root_count == CNT_NONE) || (out_res.root_count == CNT_INF))
    |-> (out_res.root_first == '0) && (out_res.root_second == '0) && !out_res.saturated)
    else $error("root fields set without a finite root");
`endif

endmodule

// ===== tb/tb_quadratic_equation_solver_unit.sv =====
module tb_quadratic_equation_solver_unit
  import qes_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // depth of the block's pipeline, used by drain
  localparam int LATENCY = 2*COEF_WIDTH + 8;
  localparam logic [COEF_WIDTH-1:0] MAX_POS = {1'b0, {(COEF_WIDTH-1){1'b1}}};
  localparam logic [COEF_WIDTH-1:0] MAX_NEG = {1'b1, {(COEF_WIDTH-1){1'b0}}};
  localparam logic [COEF_WIDTH-1:0] ONE_Q   = 1 << FRAC_BITS;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  qes_in_t                  in_coef;
  logic                     cfg_we;
  logic [CFG_IDX_WIDTH-1:0] cfg_index;
  logic [CFG_WIDTH-1:0]     cfg_wdata;
  logic                     out_strobe;
  qes_out_t                 out_res;

  quadratic_equation_solver_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_coef   (in_coef),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_strobe(out_strobe),
    .out_res   (out_res)
  );

  // tolerances as the predictor sees them
  logic [COEF_TOL_WIDTH-1:0] tol_coef;
  logic [DISC_TOL_WIDTH-1:0] tol_disc;

  qes_in_t  pending_reqs[$];   // requests waiting for the driver
  qes_out_t expected_roots[$]; // predicted results, oldest first
  int       idle_pct;          // chance of the sender sitting out a cycle
  int       n_errors;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // rounded quotient (mag << FRAC_BITS + half) / den on exact magnitudes
  function automatic logic [127:0] round_div(logic [63:0] mag, logic [63:0] half,
                                             logic [63:0] den);
    logic [127:0] num;
    num = ({64'd0, mag} << FRAC_BITS) + {64'd0, half};
    if (den == 0) return '1;
    return num / {64'd0, den};
  endfunction

  // clamp a signed quotient into the root field, flagging saturation
  function automatic logic [COEF_WIDTH-1:0] clamp_root(logic [127:0] q, logic neg,
                                                       ref logic sat);
    logic [127:0] lim;
    lim = 128'd1 << (COEF_WIDTH-1);
    if (!neg) begin
      if (q > lim - 1) begin
        sat = 1'b1;
        return MAX_POS;
      end
      return q[COEF_WIDTH-1:0];
    end
    if (q > lim) begin
      sat = 1'b1;
      return MAX_NEG;
    end
    return -q[COEF_WIDTH-1:0];
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] d);
    logic [63:0] r, cand;
    r = '0;
    for (int bit_i = 63; bit_i >= 0; bit_i--) begin
      cand = r | (64'd1 << bit_i);
      if ({64'd0, cand} * {64'd0, cand} <= d) r = cand;
    end
    return r;
  endfunction

  function automatic qes_out_t solve_quadratic(qes_in_t req);
    qes_out_t     res;
    logic         na, nb, nc, sat, dneg;
    logic [63:0]  ma, mb, mc, s;
    logic [127:0] p, q4, dm, q, q1, q2;
    logic signed [65:0] bv, n1, n2;
    logic [63:0]  m1, m2;
    na  = req.coef_a[COEF_WIDTH-1];
    nb  = req.coef_b[COEF_WIDTH-1];
    nc  = req.coef_c[COEF_WIDTH-1];
    ma  = na ? 64'(-{1'b0, req.coef_a}) & {COEF_WIDTH{1'b1}} : 64'(req.coef_a[COEF_WIDTH-1:0]);
    mb  = nb ? 64'(-{1'b0, req.coef_b}) & {COEF_WIDTH{1'b1}} : 64'(req.coef_b[COEF_WIDTH-1:0]);
    mc  = nc ? 64'(-{1'b0, req.coef_c}) & {COEF_WIDTH{1'b1}} : 64'(req.coef_c[COEF_WIDTH-1:0]);
    sat = 1'b0;
    res = '0;
    if (ma <= tol_coef) begin
      if (mb <= tol_coef) begin
        res.root_count = (mc <= tol_coef) ? CNT_INF : CNT_NONE;
      end else begin
        q = round_div(mc, mb >> 1, mb);
        res.root_first = clamp_root(q, (nb == nc) && q != 0, sat);
        res.root_count = CNT_ONE;
      end
    end else begin
      p  = {64'd0, mb} * {64'd0, mb};
      q4 = ({64'd0, ma} * {64'd0, mc}) << 2;
      if (mc != 0 && na == nc) begin
        dneg = p < q4;
        dm   = dneg ? q4 - p : p - q4;
      end else begin
        dneg = 1'b0;
        dm   = p + q4;
      end
      if (dm <= tol_disc) begin
        q = round_div(mb, ma, ma << 1);
        res.root_first = clamp_root(q, (na == nb) && q != 0, sat);
        res.root_count = CNT_ONE;
      end else if (dneg) begin
        res.root_count = CNT_NONE;
      end else begin
        s  = isqrt(dm);
        bv = nb ? -$signed({2'b0, mb}) : $signed({2'b0, mb});
        n1 = -bv - $signed({2'b0, s});
        n2 = -bv + $signed({2'b0, s});
        m1 = n1 < 0 ? 64'(-n1) : 64'(n1);
        m2 = n2 < 0 ? 64'(-n2) : 64'(n2);
        q1 = round_div(m1, ma, ma << 1);
        q2 = round_div(m2, ma, ma << 1);
        res.root_first  = clamp_root(q1, ((n1 < 0) != na) && q1 != 0, sat);
        res.root_second = clamp_root(q2, ((n2 < 0) != na) && q2 != 0, sat);
        res.root_count  = CNT_TWO;
      end
    end
    res.saturated = sat;
    return res;
  endfunction

  // driver: offers the head of the queue, predicts on acceptance
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
      start   <= 1'b1;
      in_coef <= pending_reqs[0];
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      expected_roots.push_back(solve_quadratic(in_coef));
      void'(pending_reqs.pop_front());
    end
  end

  // monitor: every strobe must match the oldest prediction
  always @(posedge clk) begin
    qes_out_t exp_res;
    if (rst_n && out_strobe) begin
      if (expected_roots.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_res);
        n_errors++;
      end else begin
        exp_res = expected_roots.pop_front();
        if (out_res.root_count !== exp_res.root_count) begin
          $display("%0t: root_count expected %0d got %0d", $time,
                   exp_res.root_count, out_res.root_count);
          n_errors++;
        end
        if (out_res.root_first !== exp_res.root_first) begin
          $display("%0t: root_first expected %h got %h", $time,
                   exp_res.root_first, out_res.root_first);
          n_errors++;
        end
        if (out_res.root_second !== exp_res.root_second) begin
          $display("%0t: root_second expected %h got %h", $time,
                   exp_res.root_second, out_res.root_second);
          n_errors++;
        end
        if (out_res.saturated !== exp_res.saturated) begin
          $display("%0t: saturated expected %b got %b", $time,
                   exp_res.saturated, out_res.saturated);
          n_errors++;
        end
      end
    end
  end

  // write one tolerance at the falling edge, mirrored into the predictor
  task automatic write_tol(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_COEF_TOL) tol_coef = val[COEF_TOL_WIDTH-1:0];
    else tol_disc = val[DISC_TOL_WIDTH-1:0];
  endtask

  // wait for every request to drain plus the pipeline depth
  task automatic drain();
    while (pending_reqs.size() > 0 || expected_roots.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [COEF_WIDTH-1:0] rand_coef();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $signed($urandom_range(8*ONE_Q)) - $signed(4*ONE_Q);
      2: return $signed(16'($urandom())) ;
      3: return ($urandom_range(1) ? MAX_NEG : MAX_POS) ^ $urandom_range(3);
      4: return $urandom_range(3) - 1;
      default: return $signed($urandom_range(200)) - 100;
    endcase
  endfunction

  // integer-root equations scaled by k: k(x-r1)(x-r2)
  function automatic qes_in_t factored_req();
    qes_in_t req;
    int k, r1, r2;
    k  = $signed($urandom_range(16)) - 8;
    if (k == 0) k = 1;
    r1 = $signed($urandom_range(40)) - 20;
    r2 = $urandom_range(3) == 0 ? r1 : $signed($urandom_range(40)) - 20;
    req.coef_a = k * ONE_Q;
    req.coef_b = -k * (r1 + r2) * ONE_Q;
    req.coef_c = k * r1 * r2 * ONE_Q;
    return req;
  endfunction

  task automatic directed_set();
    qes_in_t req;
    req = '{ONE_Q, -3*ONE_Q, 2*ONE_Q};          pending_reqs.push_back(req); // two roots
    req = '{ONE_Q, -2*ONE_Q, ONE_Q};            pending_reqs.push_back(req); // double root
    req = '{ONE_Q, 0, ONE_Q};                   pending_reqs.push_back(req); // no real root
    req = '{0, 2*ONE_Q, -4*ONE_Q};              pending_reqs.push_back(req); // linear
    req = '{0, 0, ONE_Q};                       pending_reqs.push_back(req); // linear, no root
    req = '{0, 0, 0};                           pending_reqs.push_back(req); // infinite
    req = '{MAX_NEG, MAX_NEG, MAX_NEG};         pending_reqs.push_back(req);
    req = '{MAX_POS, MAX_POS, MAX_POS};         pending_reqs.push_back(req);
    req = '{MAX_NEG, MAX_POS, MAX_NEG};         pending_reqs.push_back(req);
    req = '{0, 1, MAX_POS};                     pending_reqs.push_back(req); // linear overflow
    req = '{0, 1, MAX_NEG};                     pending_reqs.push_back(req);
    req = '{1, MAX_POS, 0};                     pending_reqs.push_back(req); // quad overflow
    req = '{1, MAX_NEG, 1};                     pending_reqs.push_back(req);
    req = '{-ONE_Q, 0, 4*ONE_Q};                pending_reqs.push_back(req);
    req = '{2, 3, 1};                           pending_reqs.push_back(req);
    req = '{-1, -1, -1};                        pending_reqs.push_back(req);
    req = '{ONE_Q, 0, 0};                       pending_reqs.push_back(req); // zero root
    req = '{0, -ONE_Q, 0};                      pending_reqs.push_back(req);
    req = '{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555}; pending_reqs.push_back(req);
    req = '{32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa}; pending_reqs.push_back(req);
  endtask

  task automatic random_set(int n);
    qes_in_t req;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(2) == 0) req = factored_req();
      else req = '{rand_coef(), rand_coef(), rand_coef()};
      pending_reqs.push_back(req);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_coef   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_COEF_TOL;
    cfg_wdata = '0;
    tol_coef  = '0;
    tol_disc  = '0;
    idle_pct  = 0;
    n_errors  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset tolerances (zero), no idling
    directed_set();
    random_set(300);
    drain();

    // small tolerances, sender idle about half the time
    write_tol(CFG_COEF_TOL, 3);
    write_tol(CFG_DISC_TOL, 32'd1000);
    idle_pct = 48;
    directed_set();
    random_set(450);
    drain();

    // largest tolerances
    write_tol(CFG_COEF_TOL, 32'hffff_ffff);
    write_tol(CFG_DISC_TOL, 32'hffff_ffff);
    idle_pct = 20;
    directed_set();
    random_set(450);
    drain();

    // back to mid values, bursty
    write_tol(CFG_COEF_TOL, 32'h0000_8000);
    write_tol(CFG_DISC_TOL, 32'h8000_0000);
    idle_pct = 0;
    random_set(450);
    drain();

    if (n_errors == 0) $display("[quadratic_equation_solver_unit] OK");
    else $display("[quadratic_equation_solver_unit] ERROR");
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #2ms;
    $display("[quadratic_equation_solver_unit] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/qes_pkg.sv
rtl/quadratic_equation_solver_unit.sv
tb/tb_quadratic_equation_solver_unit.sv
